@@ sv/lmce_pkg.sv @@
package lmce_pkg;

    localparam int LMCE_QUEUE_DEPTH = 2;
    localparam int COL_W = 7;
    localparam int MAX_SEQ = 7;
    localparam int POS_W = 3;

    localparam logic [COL_W-1:0] COL_MAX = 7'd127;
    localparam logic [COL_W-1:0] WRAP_LIMIT_RESET = 7'd66;
    localparam logic [COL_W-1:0] WRAP_RESTART_RESET = 7'd8;

    // register indexes
    localparam logic [0:0] CFG_IDX_WRAP_LIMIT = 1'b0;
    localparam logic [0:0] CFG_IDX_WRAP_RESTART = 1'b1;

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CTRL_END = 8'h20;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_NL_ESC,
        KIND_ESC2,
        KIND_OCTAL
    } kind_t;

    typedef struct packed {
        logic       wrap;
        kind_t      kind;
        logic [7:0] chr;
    } job_t;

endpackage

@@ sv/lmce_front.sv @@
module lmce_front
    import lmce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [COL_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       char_in,
    input  logic             escape_mode,
    input  logic             column_load,
    input  logic [COL_W-1:0] column_value,
    input  logic             q_full,
    output logic             push,
    output job_t             job
);

    logic [COL_W-1:0] wrap_limit_reg;
    logic [COL_W-1:0] wrap_restart_reg;
    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] column_next;
    logic             prev_space_reg;
    logic             prev_space_next;

    logic [COL_W-1:0] col_base;
    logic [COL_W-1:0] col_after_wrap;
    logic [COL_W:0]   col_sum;
    logic [COL_W:0]   col_add;
    logic             is_esc2;
    logic             is_octal;

    assign in_ready = !q_full;
    assign push = in_valid && in_ready;

    assign col_base = column_load ? column_value : column_reg;
    assign is_esc2 = (char_in == CH_BS) || (char_in == CH_TAB) || (char_in == CH_BSLASH);
    assign is_octal = !is_esc2
        && (char_in[7] || (char_in < CH_CTRL_END) || (char_in == CH_DEL));

    always_comb
    begin
        job.chr = char_in;
        job.wrap = 1'b0;
        job.kind = KIND_PLAIN;
        column_next = col_base;
        prev_space_next = (char_in == CH_SPACE);
        col_after_wrap = col_base;
        col_add = (COL_W+1)'(1);
        col_sum = '0;
        if (escape_mode)
        begin
            if (char_in == CH_NL)
            begin
                job.kind = prev_space_reg ? KIND_NL_ESC : KIND_PLAIN;
                prev_space_next = 1'b0;
            end
            else
            begin
                job.wrap = (col_base >= wrap_limit_reg);
                col_after_wrap = job.wrap ? wrap_restart_reg : col_base;
                if (is_esc2)
                begin
                    job.kind = KIND_ESC2;
                    col_add = (COL_W+1)'(2);
                    prev_space_next = 1'b0;
                end
                else if (is_octal)
                begin
                    job.kind = KIND_OCTAL;
                    col_add = (COL_W+1)'(4);
                    prev_space_next = 1'b0;
                end
                col_sum = {1'b0, col_after_wrap} + col_add;
                // saturate at the top column
                column_next = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_limit_reg <= WRAP_LIMIT_RESET;
            wrap_restart_reg <= WRAP_RESTART_RESET;
            column_reg <= '0;
            prev_space_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_WRAP_LIMIT: wrap_limit_reg <= cfg_wdata;
                    CFG_IDX_WRAP_RESTART: wrap_restart_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (push)
            begin
                column_reg <= column_next;
                prev_space_reg <= prev_space_next;
            end
        end
    end

`ifndef SYNTHESIS
    // a printing byte in escape mode always leaves the column above zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && escape_mode && (char_in != CH_NL)) |=> (column_reg != '0))
        else $error("column did not advance");
`endif

endmodule

@@ sv/lmce_fifo.sv @@
module lmce_fifo
    import lmce_pkg::*;
#(
    parameter int DEPTH = LMCE_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic q_valid,
    output job_t q_job,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

@@ sv/lmce_back.sv @@
module lmce_back
    import lmce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             last_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic             load;
    logic [POS_W-1:0] wrap_len;
    logic [POS_W-1:0] pre_len;
    logic [POS_W-1:0] rel;
    logic [7:0]       final_byte;
    logic [7:0]       cur_byte;
    logic             cur_last;

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last_of_run = last_reg;

    assign load = !out_valid_reg || out_ready;
    assign wrap_len = q_job.wrap ? POS_W'(3) : POS_W'(0);
    assign rel = pos_reg - wrap_len;

    always_comb
    begin
        case (q_job.kind)
            KIND_NL_ESC: pre_len = POS_W'(2);
            KIND_ESC2: pre_len = POS_W'(1);
            KIND_OCTAL: pre_len = POS_W'(3);
            default: pre_len = POS_W'(0);
        endcase
    end

    always_comb
    begin
        case (q_job.kind)
            KIND_ESC2:
            begin
                if (q_job.chr == CH_BS)
                    final_byte = CH_LOWER_B;
                else if (q_job.chr == CH_TAB)
                    final_byte = CH_LOWER_T;
                else
                    final_byte = CH_BSLASH;
            end
            KIND_OCTAL: final_byte = CH_ZERO | {5'b0, q_job.chr[2:0]};
            default: final_byte = q_job.chr;
        endcase
    end

    // byte at the current position of the run
    always_comb
    begin
        cur_last = 1'b0;
        if (pos_reg < wrap_len)
        begin
            case (pos_reg)
                POS_W'(0): cur_byte = CH_BSLASH;
                POS_W'(1): cur_byte = CH_NL;
                default: cur_byte = CH_TAB;
            endcase
        end
        else if (rel < pre_len)
        begin
            if (rel == '0)
                cur_byte = CH_BSLASH;
            else if (q_job.kind == KIND_NL_ESC)
                cur_byte = CH_LOWER_N;
            else if (rel == POS_W'(1))
                cur_byte = CH_ZERO | {6'b0, q_job.chr[7:6]};
            else
                cur_byte = CH_ZERO | {5'b0, q_job.chr[5:3]};
        end
        else
        begin
            cur_byte = final_byte;
            cur_last = 1'b1;
        end
    end

    assign pop = q_valid && load && cur_last;
    assign pos_next = pop ? '0 : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg <= 1'b0;
            pos_reg <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= q_valid;
            if (q_valid)
            begin
                last_reg <= cur_last;
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_valid)
        begin
            out_byte_reg <= cur_byte;
        end
    end

`ifndef SYNTHESIS
    // mid-run means the job is still at the queue head
    assert property (@(posedge clk) disable iff (!rst_n) (pos_reg != '0) |-> q_valid)
        else $error("run position without job");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> (out_valid_reg && !last_reg))
        else $error("run position out of step with output");
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg < POS_W'(MAX_SEQ))
        else $error("run longer than longest sequence");
`endif

endmodule

@@ sv/list_mode_char_escaper.sv @@
// channel   signals                                         handshake
// -------   ---------------------------------------------   ---------------------
// in        char_in, escape_mode, column_load, column_value  in_valid / in_ready
// out       out_byte, last_of_run                           out_valid / out_ready
// cfg       cfg_index, cfg_wdata                            cfg_we, no wait
//
// an item that yields one byte goes through every cycle while out_ready is high;
// an item of n bytes (1 to 7) holds the output serializer, one byte a cycle while
// out_ready is high; accepted items pass the job queue, then the output register
// reset clears column, space flag, queue and output; wrap registers go to 66 and 8
// in_ready drops only when the job queue is full; out_ready low holds the byte
module list_mode_char_escaper
    import lmce_pkg::*;
#(
    parameter int QUEUE_DEPTH = LMCE_QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [COL_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       char_in,
    input  logic             escape_mode,
    input  logic             column_load,
    input  logic [COL_W-1:0] column_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             last_of_run
);

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    job_t push_job;
    job_t q_job;

    lmce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .escape_mode  (escape_mode),
        .column_load  (column_load),
        .column_value (column_value),
        .q_full       (q_full),
        .push         (push),
        .job          (push_job)
    );

    lmce_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop)
    );

    lmce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (q_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
